// ----- design/asma_pkg.sv -----
// Package for the accelerometer scale and moving-average block.
// Holds sizes, the sample word type, controller states and control structs.
// No dependencies.
`default_nettype none

package asma_pkg;

  localparam int DEPTH     = 16;
  localparam int SLOT_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int RAW_W     = 16;
  localparam int MAX_SHIFT = 4;
  localparam int VAL_W     = RAW_W + MAX_SHIFT + 1;
  localparam int SUM_W     = VAL_W + $clog2(DEPTH);
  localparam int DIV_W     = SUM_W + (SUM_W % 2);
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int OUT_W     = 20;
  localparam int AXES      = 3;

  localparam logic [1:0] RANGE_RESET = 2'd3;

  typedef struct packed {
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
    logic [7:0] z_high;
    logic [7:0] z_low;
  } sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic acc;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- design/asma_if.sv -----
// Valid/ready channel interfaces for sample words and mean words.
// Depends on nothing.
`default_nettype none

interface asma_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_high;
  logic [7:0] x_low;
  logic [7:0] y_high;
  logic [7:0] y_low;
  logic [7:0] z_high;
  logic [7:0] z_low;

  modport source (output valid, x_high, x_low, y_high, y_low, z_high, z_low, input ready);
  modport sink   (input valid, x_high, x_low, y_high, y_low, z_high, z_low, output ready);
endinterface

interface asma_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] mean_x;
  logic signed [19:0] mean_y;
  logic signed [19:0] mean_z;

  modport source (output valid, mean_x, mean_y, mean_z, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, output ready);
endinterface

`default_nettype wire

// ----- design/asma_div.sv -----
// Signed-by-unsigned divider, two quotient bits per step, truncates toward zero.
// Depends on asma_pkg.
`default_nettype none

module asma_div (
  input  wire logic                              clk,
  input  wire logic                              start,
  input  wire logic                              step,
  input  wire logic signed [asma_pkg::SUM_W-1:0] dividend,
  input  wire logic [asma_pkg::CNT_W-1:0]        divisor,
  output logic signed [asma_pkg::OUT_W-1:0]      quotient
);

  logic                           neg_r;
  logic [asma_pkg::CNT_W-1:0]     den_r;
  logic [asma_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [asma_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [asma_pkg::SUM_W-1:0]     mag;
  logic [asma_pkg::DIV_W-1:0]     res;

  assign mag = dividend[asma_pkg::SUM_W-1] ? asma_pkg::SUM_W'(-dividend)
                                           : asma_pkg::SUM_W'(dividend);

  always_comb begin
    logic [asma_pkg::CNT_W:0] sh;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < 2; k++) begin
      sh      = {rem_nxt, quo_nxt[asma_pkg::DIV_W-1]};
      quo_nxt = {quo_nxt[asma_pkg::DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt    = asma_pkg::CNT_W'(sh - {1'b0, den_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh[asma_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[asma_pkg::SUM_W-1];
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= asma_pkg::DIV_W'(mag);
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign res      = neg_r ? -quo_r : quo_r;
  assign quotient = res[asma_pkg::OUT_W-1:0];

endmodule

`default_nettype wire

// ----- design/asma_ctrl.sv -----
// Controller state machine: sequences capture, accumulate, divide and output load.
// Depends on asma_pkg.
`default_nettype none

module asma_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire asma_pkg::status_t status,
  output asma_pkg::cmd_t         cmd
);

  asma_pkg::state_t             state_r, state_nxt;
  logic [asma_pkg::STEP_W-1:0]  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asma_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      asma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = asma_pkg::ST_ACC;
        end
      end
      asma_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = asma_pkg::ST_LOAD;
      end
      asma_pkg::ST_LOAD: begin
        cmd.div_start = 1'b1;
        step_nxt      = asma_pkg::STEP_W'(asma_pkg::DIV_STEPS - 1);
        state_nxt     = asma_pkg::ST_DIV;
      end
      asma_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = asma_pkg::ST_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      asma_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = asma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = asma_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/asma_dp.sv -----
// Datapath: range register, scaling, window ring memory, running sums,
// per-axis dividers and output register. Depends on asma_pkg and asma_div.
`default_nettype none

module asma_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_wdata,
  input  wire asma_pkg::sample_t            sample,
  input  wire asma_pkg::cmd_t               cmd,
  output asma_pkg::status_t                 status,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic signed [asma_pkg::OUT_W-1:0] mean_x,
  output logic signed [asma_pkg::OUT_W-1:0] mean_y,
  output logic signed [asma_pkg::OUT_W-1:0] mean_z
);

  localparam int VW = asma_pkg::VAL_W;

  logic [1:0]                        range_r;
  logic [asma_pkg::SLOT_W-1:0]       slot_r;
  logic [asma_pkg::CNT_W-1:0]        fill_r, count;
  logic                              full;
  logic signed [VW-1:0]              val_r [asma_pkg::AXES];
  logic signed [VW-1:0]              raw_ext [asma_pkg::AXES];
  logic [15:0]                       raw [asma_pkg::AXES];
  logic [2:0]                        shift;
  logic [asma_pkg::AXES*VW-1:0]      mem_r [asma_pkg::DEPTH];
  logic [asma_pkg::AXES*VW-1:0]      rd_q_r;
  logic signed [asma_pkg::SUM_W-1:0] sum_r [asma_pkg::AXES];
  logic signed [asma_pkg::SUM_W-1:0] sum_nxt [asma_pkg::AXES];
  logic signed [asma_pkg::OUT_W-1:0] quo [asma_pkg::AXES];
  logic                              out_valid_r;
  logic signed [asma_pkg::OUT_W-1:0] mean_r [asma_pkg::AXES];

  assign raw[0] = {sample.x_high, sample.x_low};
  assign raw[1] = {sample.y_high, sample.y_low};
  assign raw[2] = {sample.z_high, sample.z_low};
  assign shift  = {1'b0, range_r} + 3'd1;

  always_comb begin
    for (int a = 0; a < asma_pkg::AXES; a++) begin
      raw_ext[a] = VW'(signed'(raw[a]));
    end
  end

  assign full  = (fill_r == asma_pkg::CNT_W'(asma_pkg::DEPTH));
  assign count = full ? fill_r : fill_r + 1'b1;

  always_comb begin
    logic signed [VW-1:0] old;
    for (int a = 0; a < asma_pkg::AXES; a++) begin
      old        = rd_q_r[a*VW +: VW];
      sum_nxt[a] = sum_r[a] - (full ? asma_pkg::SUM_W'(old) : '0)
                   + asma_pkg::SUM_W'(val_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= asma_pkg::RANGE_RESET;
    end else if (cfg_we) begin
      range_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int a = 0; a < asma_pkg::AXES; a++) begin
        val_r[a] <= raw_ext[a] <<< shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_q_r <= mem_r[slot_r];
    end
    if (cmd.acc) begin
      mem_r[slot_r] <= {val_r[2], val_r[1], val_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
      for (int a = 0; a < asma_pkg::AXES; a++) begin
        sum_r[a] <= '0;
      end
    end else if (cmd.acc) begin
      fill_r <= count;
      slot_r <= (slot_r == asma_pkg::SLOT_W'(asma_pkg::DEPTH - 1)) ? '0 : slot_r + 1'b1;
      for (int a = 0; a < asma_pkg::AXES; a++) begin
        sum_r[a] <= sum_nxt[a];
      end
    end
  end

  for (genvar g = 0; g < asma_pkg::AXES; g++) begin : g_div
    asma_div u_div (
      .clk      (clk),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_r[g]),
      .divisor  (fill_r),
      .quotient (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int a = 0; a < asma_pkg::AXES; a++) begin
        mean_r[a] <= quo[a];
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign mean_x          = mean_r[0];
  assign mean_y          = mean_r[1];
  assign mean_z          = mean_r[2];

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= asma_pkg::CNT_W'(asma_pkg::DEPTH))
    else $error("fill count above window depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before taken");

  a_fill_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |=> (fill_r != '0))
    else $error("fill count zero after accumulate");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.acc, cmd.div_start, cmd.div_step, cmd.out_load}))
    else $error("overlapping datapath commands");
`endif

endmodule

`default_nettype wire

// ----- design/accel_scale_moving_average.sv -----
// Top level: accelerometer scaling with a moving-average window per axis.
// A new sample is taken only in the idle state, once the two-bit-per-cycle divider is done and the mean is loaded.
// A finished mean waits in the output register while the next sample is taken.
// Synchronous active-low reset: empty window, zero sums, range code 3 (scale by 16).
// Depends on asma_pkg, asma_if, asma_ctrl, asma_dp.
`default_nettype none

module accel_scale_moving_average (
  input  wire logic   clk,
  input  wire logic   rst_n,
  asma_in_if.sink     in_ch,
  asma_out_if.source  out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  asma_pkg::cmd_t    cmd;
  asma_pkg::status_t status;
  asma_pkg::sample_t sample;

  assign sample.x_high = in_ch.x_high;
  assign sample.x_low  = in_ch.x_low;
  assign sample.y_high = in_ch.y_high;
  assign sample.y_low  = in_ch.y_low;
  assign sample.z_high = in_ch.z_high;
  assign sample.z_low  = in_ch.z_low;

  asma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  asma_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .mean_x    (out_ch.mean_x),
    .mean_y    (out_ch.mean_y),
    .mean_z    (out_ch.mean_z)
  );

endmodule

`default_nettype wire

// ----- test/accel_scale_moving_average_tb.sv -----
// Testbench for accel_scale_moving_average: scaled per-axis window means.
// Drives sample words and range writes and checks each mean word against its own predictor.
// Depends on asma_pkg, asma_if and the accel_scale_moving_average RTL.
module accel_scale_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asma_pkg::*;

  localparam int LATENCY         = 16;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int PRINT_CAP       = 100;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
  } means_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  asma_in_if  in_ch ();
  asma_out_if out_ch ();

  accel_scale_moving_average i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sample_t sample_queue[$];
  means_t  mean_fifo[$];
  sample_t held;

  logic [1:0]  range_q = RANGE_RESET;
  logic [3:0]  ranges_seen = 4'b1000;
  int          window[AXES][DEPTH];
  longint      win_sum[AXES];
  int          slot_q;
  int          fill_q;

  int send_idle;
  int recv_idle;
  int n_samples;
  int n_means;
  int err_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int scale_axis(logic [7:0] hi, logic [7:0] lo);
    logic signed [15:0] raw;
    raw = {hi, lo};
    return int'(raw) <<< (int'(range_q) + 1);
  endfunction

  function automatic means_t push_sample(sample_t s);
    int     v[AXES];
    logic [OUT_W-1:0] m[AXES];
    longint n;
    bit     full;
    v[0] = scale_axis(s.x_high, s.x_low);
    v[1] = scale_axis(s.y_high, s.y_low);
    v[2] = scale_axis(s.z_high, s.z_low);
    full = (fill_q == DEPTH);
    n = full ? DEPTH : fill_q + 1;
    for (int a = 0; a < AXES; a++) begin
      if (full) win_sum[a] -= window[a][slot_q];
      window[a][slot_q] = v[a];
      win_sum[a] += v[a];
      m[a] = OUT_W'(win_sum[a] / n);
    end
    fill_q = int'(n);
    slot_q = (slot_q + 1) % DEPTH;
    return '{x: m[0], y: m[1], z: m[2]};
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(16)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    sample_queue.push_back(sample_t'({x, y, z}));
  endtask

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    if (err_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what,
               $signed(got), $signed(want));
    err_count++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_ch.valid || mean_fifo.size() != 0);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic write_range(logic [1:0] r);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    range_q = r;
    ranges_seen[r] = 1'b1;
  endtask

  // sender: predict on accept, then offer the next word or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        mean_fifo.push_back(push_sample(held));
        n_samples++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          held = sample_queue.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.x_high <= held.x_high;
          in_ch.x_low  <= held.x_low;
          in_ch.y_high <= held.y_high;
          in_ch.y_low  <= held.y_low;
          in_ch.z_high <= held.z_high;
          in_ch.z_low  <= held.z_low;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted mean word, stall at random
  always @(posedge clk) begin
    means_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_means++;
      if (mean_fifo.size() == 0) begin
        report_mismatch("unexpected mean word, x", out_ch.mean_x, '0);
      end else begin
        want = mean_fifo.pop_front();
        if (out_ch.mean_x !== want.x) report_mismatch("mean_x", out_ch.mean_x, want.x);
        if (out_ch.mean_y !== want.y) report_mismatch("mean_y", out_ch.mean_y, want.y);
        if (out_ch.mean_z !== want.z) report_mismatch("mean_z", out_ch.mean_z, want.z);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d means outstanding", cycle_count,
               mean_fifo.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [1:0] r;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.x_high = '0;
    in_ch.x_low  = '0;
    in_ch.y_high = '0;
    in_ch.y_low  = '0;
    in_ch.z_high = '0;
    in_ch.z_low  = '0;
    out_ch.ready = 1'b0;
    send_idle    = 16;
    recv_idle    = 45;
    slot_q       = 0;
    fill_q       = 0;
    for (int a = 0; a < AXES; a++) win_sum[a] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // partial fill, extremes, then full window with eviction and wrap at reset range
    queue_sample(16'h7fff, 16'h8000, 16'h0000);
    queue_sample(16'h8000, 16'h7fff, 16'hffff);
    queue_sample(16'h0000, 16'hffff, 16'h7fff);
    queue_sample(16'hffff, 16'h0001, 16'h8000);
    queue_sample(16'h00ff, 16'hff00, 16'h0080);
    queue_sample(16'h7f80, 16'h8001, 16'h0100);
    repeat (10) queue_sample(16'h7fff, 16'h7fff, 16'h7fff);
    queue_sample(16'h8000, 16'h8000, 16'h8000);
    queue_sample(16'h8000, 16'h8000, 16'h8000);
    wait_drained();

    // narrow range while old entries keep their scale
    write_range(2'd0);
    queue_sample(16'h0001, 16'hffff, 16'h7fff);
    queue_sample(16'h8000, 16'h7fff, 16'h0000);
    queue_sample(16'haaaa, 16'h5555, 16'hff01);
    queue_sample(16'h5555, 16'haaaa, 16'h00fe);
    queue_sample(16'h7fff, 16'h8000, 16'hfffe);
    queue_sample(16'h0000, 16'h0000, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == 0) r = 2'd1;
      else if (p == 1) r = 2'd2;
      else if (p == PHASES - 2) r = 2'd0;
      else if (p == PHASES - 1) r = 2'd3;
      else r = 2'($urandom_range(3));
      write_range(r);
      if (p == 4) begin
        send_idle = 45;
        recv_idle = 16;
      end else if (p == 7) begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (ITEMS_PER_PHASE) queue_sample(rand_axis(), rand_axis(), rand_axis());
    end
    wait_drained();

    $display("covered %0d samples and %0d mean words over range set %b,", n_samples, n_means,
             ranges_seen);
    $display("partial and full windows, slot wrap, sender and receiver stalls; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/asma_pkg.sv
design/asma_if.sv
design/asma_div.sv
design/asma_ctrl.sv
design/asma_dp.sv
design/accel_scale_moving_average.sv
test/accel_scale_moving_average_tb.sv
